[rtl/ccts_pkg.sv]
// Package for the colour cube separation block: field widths, mode codes,
// the two-node blend function and the blend control struct.
// No dependencies.
package ccts_pkg;

    localparam int WEIGHT_W = 9;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
    localparam int CNT_W = 5;

    localparam logic [1:0] MODE_LOAD_LIN  = 2'd0;
    localparam logic [1:0] MODE_LOAD_CUBE = 2'd1;
    localparam logic [1:0] MODE_RGB       = 2'd2;
    localparam logic [1:0] MODE_GRAY      = 2'd3;

    typedef logic [7:0][7:0] node_set_t;

    typedef struct packed {
        logic b_en;
        logic g_en;
    } blend_ctrl_t;

    // (lo*w + hi*(256-w)) / 256; the sum never exceeds 255*256.
    function automatic logic [7:0] blend(input logic [7:0] lo, input logic [7:0] hi,
                                         input logic [WEIGHT_W-1:0] w);
        logic [16:0] p_lo;
        logic [16:0] p_hi;
        logic [16:0] sum;
        p_lo = 17'(lo) * 17'(w);
        p_hi = 17'(hi) * 17'(WEIGHT_ONE - w);
        sum  = p_lo + p_hi;
        return sum[15:8];
    endfunction

endpackage

[rtl/color_cube_trilinear_separation.sv]
// Colour cube separation top level. For each channel an RGB pixel makes eight reads
// on the single cube port and then the blue, green and red blends; a gray pixel
// makes two cube reads per channel before the same blends.
// One item is in work at a time. Reset (rst_n, asynchronous) sets the cube size
// register to 2 and the channel count to 1; the table and cube memories are not cleared.
// Depends on ccts_pkg and ccts_blend.
module color_cube_trilinear_separation
    import ccts_pkg::*;
#(
    parameter int CUBE_MAX     = 16,
    parameter int MAX_CHANNELS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // table_index[7:0], node_index[19:8], channel_index[22:20], load_value[30:23],
    // red[38:31], green[46:39], blue[54:47], zero fill above
    input  logic [55:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // level[7:0]
    output logic [7:0]  m_tdata,
    // out_channel[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    localparam int NODE_COUNT = CUBE_MAX * CUBE_MAX * CUBE_MAX;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int DEPTH      = NODE_COUNT * MAX_CHANNELS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int SW         = $clog2(CUBE_MAX + 1);
    localparam int IDX_W      = $clog2(CUBE_MAX);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LIN   = 4'd1;
    localparam logic [3:0] ST_IDX   = 4'd2;
    localparam logic [3:0] ST_BASE1 = 4'd3;
    localparam logic [3:0] ST_BASE2 = 4'd4;
    localparam logic [3:0] ST_READ  = 4'd5;
    localparam logic [3:0] ST_BLB   = 4'd6;
    localparam logic [3:0] ST_BLG   = 4'd7;
    localparam logic [3:0] ST_BLR   = 4'd8;

    // Input fields.
    logic [7:0]  table_index;
    logic [11:0] node_index;
    logic [2:0]  channel_index;
    logic [7:0]  load_value;
    logic [1:0]  mode;
    assign table_index   = s_tdata[7:0];
    assign node_index    = s_tdata[19:8];
    assign channel_index = s_tdata[22:20];
    assign load_value    = s_tdata[30:23];
    assign mode          = s_tuser;

    logic [4:0] grid_size_reg;
    logic [3:0] chan_count_reg;
    logic [3:0] state_reg;
    logic       gray_reg;
    logic [2:0][7:0] sample_reg;
    logic [2:0][7:0] lv_reg;
    logic [1:0] lcnt_reg;
    logic [3:0] rcnt_reg;
    logic [CNT_W-1:0] ch_reg;
    logic [2:0][IDX_W-1:0] idx_reg;
    logic [WEIGHT_W-1:0] bw_reg;
    logic [WEIGHT_W-1:0] gw_reg;
    logic [WEIGHT_W-1:0] rw_reg;
    logic [NODE_W-1:0] ss_reg;
    logic [NODE_W-1:0] t_reg;
    logic [NODE_W-1:0] base_reg;
    node_set_t nodes_reg;
    logic        out_valid_reg;
    logic [7:0]  level_reg;
    logic [2:0]  och_reg;
    logic        last_reg;

    logic [7:0] lin_mem [256];
    logic [7:0] cube_mem [DEPTH];
    logic [7:0] lin_q;
    logic [7:0] cube_q;

    // Effective configuration with out-of-range values pulled into range.
    logic [SW-1:0]    s_eff;
    logic [CNT_W-1:0] n_eff;
    always_comb
    begin
        if (grid_size_reg < 5'd2)
            s_eff = SW'(2);
        else if (32'(grid_size_reg) > CUBE_MAX)
            s_eff = SW'(CUBE_MAX);
        else
            s_eff = SW'(grid_size_reg);
        if (chan_count_reg == 4'd0)
            n_eff = CNT_W'(1);
        else if (32'(chan_count_reg) > MAX_CHANNELS)
            n_eff = CNT_W'(MAX_CHANNELS);
        else
            n_eff = CNT_W'(chan_count_reg);
    end

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg  <= 5'd2;
            chan_count_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index)
                chan_count_reg <= cfg_data[3:0];
            else
                grid_size_reg <= cfg_data;
        end
    end

    // Linearisation table memory, one write and one registered read.
    logic [7:0] lin_raddr;
    assign lin_raddr = sample_reg[lcnt_reg];
    always_ff @(posedge clk)
    begin
        if (accept && mode == MODE_LOAD_LIN)
            lin_mem[table_index] <= load_value;
        lin_q <= lin_mem[lin_raddr];
    end

    // Cube read address: node offset by read slot (bit 0 blue, bit 1 green, bit 2 red).
    logic [NODE_W-1:0] diag;
    logic [NODE_W-1:0] offset;
    logic [NODE_W-1:0] rd_node;
    logic [ADDR_W-1:0] cube_raddr;
    logic [ADDR_W-1:0] cube_waddr;
    logic              cube_we;
    assign diag = ss_reg + NODE_W'(s_eff) + NODE_W'(1);
    always_comb
    begin
        if (gray_reg)
            offset = rcnt_reg[0] ? diag : '0;
        else
            offset = (rcnt_reg[2] ? ss_reg : '0) + (rcnt_reg[1] ? NODE_W'(s_eff) : '0)
                     + NODE_W'(rcnt_reg[0]);
    end
    assign rd_node    = base_reg + offset;
    assign cube_raddr = ADDR_W'(rd_node) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(ch_reg);
    assign cube_waddr = ADDR_W'(node_index) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(channel_index);
    assign cube_we    = accept && mode == MODE_LOAD_CUBE && 32'(node_index) < NODE_COUNT
                        && 32'(channel_index) < MAX_CHANNELS;

    // Cube memory, one write and one registered read.
    always_ff @(posedge clk)
    begin
        if (cube_we)
            cube_mem[cube_waddr] <= load_value;
        cube_q <= cube_mem[cube_raddr];
    end

    // Node index and weight of each linearised sample.
    logic [2:0][IDX_W-1:0]    idx_c;
    logic [2:0][WEIGHT_W-1:0] w_c;
    always_comb
    begin
        logic [8+SW-1:0] prod;
        for (int i = 0; i < 3; i++)
        begin
            prod     = (8+SW)'(lv_reg[i]) * (8+SW)'(s_eff - SW'(1));
            idx_c[i] = IDX_W'(prod[8+SW-1:8]);
            w_c[i]   = (lv_reg[i] == 8'd0) ? WEIGHT_ONE : WEIGHT_W'(8'd255 - prod[7:0]);
        end
    end

    blend_ctrl_t blend_ctrl;
    logic [7:0]  level_c;
    assign blend_ctrl.b_en = (state_reg == ST_BLB);
    assign blend_ctrl.g_en = (state_reg == ST_BLG);

    ccts_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (blend_ctrl),
        .nodes (nodes_reg),
        .bw    (bw_reg),
        .gw    (gw_reg),
        .rw    (rw_reg),
        .level (level_c)
    );

    logic [1:0] lin_reads;
    logic [3:0] cube_reads;
    assign lin_reads  = gray_reg ? 2'd1 : 2'd3;
    assign cube_reads = gray_reg ? 4'd2 : 4'd8;

    // Sequencer: table reads, index set-up, cube reads and blends per channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gray_reg      <= 1'b0;
            sample_reg    <= '0;
            lv_reg        <= '0;
            lcnt_reg      <= '0;
            rcnt_reg      <= '0;
            ch_reg        <= '0;
            idx_reg       <= '0;
            bw_reg        <= '0;
            gw_reg        <= '0;
            rw_reg        <= '0;
            ss_reg        <= '0;
            t_reg         <= '0;
            base_reg      <= '0;
            nodes_reg     <= '0;
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
            och_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            // Output register: loaded from the red blend, cleared once taken.
            if (state_reg == ST_BLR && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (mode == MODE_RGB || mode == MODE_GRAY))
                    begin
                        gray_reg   <= (mode == MODE_GRAY);
                        sample_reg <= s_tdata[54:31];
                        lcnt_reg   <= '0;
                        state_reg  <= ST_LIN;
                    end
                end
                ST_LIN:
                begin
                    if (lcnt_reg != 2'd0)
                        lv_reg[lcnt_reg - 2'd1] <= lin_q;
                    if (lcnt_reg == lin_reads)
                        state_reg <= ST_IDX;
                    else
                        lcnt_reg <= lcnt_reg + 2'd1;
                end
                ST_IDX:
                begin
                    idx_reg <= idx_c;
                    if (gray_reg)
                    begin
                        bw_reg <= w_c[0];
                        gw_reg <= WEIGHT_ONE;
                        rw_reg <= WEIGHT_ONE;
                    end
                    else
                    begin
                        rw_reg <= w_c[0];
                        gw_reg <= w_c[1];
                        bw_reg <= w_c[2];
                    end
                    state_reg <= ST_BASE1;
                end
                ST_BASE1:
                begin
                    ss_reg <= NODE_W'(s_eff) * NODE_W'(s_eff);
                    if (gray_reg)
                        t_reg <= NODE_W'(s_eff) * NODE_W'(s_eff) + NODE_W'(s_eff) + NODE_W'(1);
                    else
                        t_reg <= NODE_W'(idx_reg[0]) * NODE_W'(s_eff) + NODE_W'(idx_reg[1]);
                    state_reg <= ST_BASE2;
                end
                ST_BASE2:
                begin
                    if (gray_reg)
                        base_reg <= NODE_W'(idx_reg[0]) * t_reg;
                    else
                        base_reg <= t_reg * NODE_W'(s_eff) + NODE_W'(idx_reg[2]);
                    ch_reg    <= '0;
                    rcnt_reg  <= '0;
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    if (rcnt_reg != 4'd0)
                        nodes_reg[3'(rcnt_reg - 4'd1)] <= cube_q;
                    if (rcnt_reg == cube_reads)
                        state_reg <= ST_BLB;
                    else
                        rcnt_reg <= rcnt_reg + 4'd1;
                end
                ST_BLB:
                begin
                    state_reg <= ST_BLG;
                end
                ST_BLG:
                begin
                    state_reg <= ST_BLR;
                end
                ST_BLR:
                begin
                    if (out_free)
                    begin
                        level_reg     <= level_c;
                        och_reg       <= ch_reg[2:0];
                        last_reg      <= (ch_reg == n_eff - CNT_W'(1));
                        if (ch_reg == n_eff - CNT_W'(1))
                            state_reg <= ST_IDLE;
                        else
                        begin
                            ch_reg    <= ch_reg + CNT_W'(1);
                            rcnt_reg  <= '0;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = level_reg;
    assign m_tuser  = och_reg;
    assign m_tlast  = last_reg;

endmodule

[rtl/ccts_blend.sv]
// Blend datapath: blue, then green, then red two-node blends over eight node bytes.
// Depends on ccts_pkg.
module ccts_blend
    import ccts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  blend_ctrl_t         ctrl,
    input  node_set_t           nodes,
    input  logic [WEIGHT_W-1:0] bw,
    input  logic [WEIGHT_W-1:0] gw,
    input  logic [WEIGHT_W-1:0] rw,
    output logic [7:0]          level
);

    logic [3:0][7:0] b_reg;
    logic [1:0][7:0] g_reg;

    // Blue blends, one per green/red corner pair, then green blends, one per red corner.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
            g_reg <= '0;
        end
        else
        begin
            if (ctrl.b_en)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    b_reg[i] <= blend(nodes[2*i], nodes[2*i+1], bw);
                end
            end
            if (ctrl.g_en)
            begin
                g_reg[0] <= blend(b_reg[0], b_reg[1], gw);
                g_reg[1] <= blend(b_reg[2], b_reg[3], gw);
            end
        end
    end

    // Red blend feeds the output register; the result never exceeds 255.
    assign level = blend(g_reg[0], g_reg[1], rw);

endmodule
